>>> hw/rtl/btr_pkg.sv
// Shared types and constants of the bitmap text rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package btr_pkg;

    // Request codes of an input item.
    localparam logic [1:0] REQ_FONT  = 2'd0;
    localparam logic [1:0] REQ_BEGIN = 2'd1;
    localparam logic [1:0] REQ_CHAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FONT_W  = 2'd0;
    localparam logic [1:0] CFG_FONT_H  = 2'd1;
    localparam logic [1:0] CFG_SPACING = 2'd2;

    // Spacing modes.
    localparam logic [1:0] SP_MONO = 2'd0;
    localparam logic [1:0] SP_VAR  = 2'd1;
    localparam logic [1:0] SP_TAB  = 2'd2;

    // Register values after reset.
    localparam logic [3:0] RST_FONT_W  = 4'd5;
    localparam logic [4:0] RST_FONT_H  = 5'd7;
    localparam logic [1:0] RST_SPACING = SP_MONO;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_BANG  = 8'd33;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_TILDE = 8'd126;

    // Largest byte address that the font address field can carry.
    localparam int FONT_ADDR_MAX = 2047;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [10:0]        font_addr;
        logic [7:0]         font_byte;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] row_y;
        logic signed [15:0] region_x;
        logic [3:0]         clear_count;
        logic [7:0]         ink_bits;
        logic               last_row;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_ADD  = 2'd0,
        ALU_MUL  = 2'd1,
        ALU_CSUB = 2'd2,
        ALU_SLT  = 2'd3
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [15:0] a;
        logic [15:0] b;
    } t_alu_req;

endpackage

`default_nettype wire

>>> hw/rtl/btr_alu.sv
// Shared arithmetic unit: signed add, small multiply, compare-subtract, signed less-than.
`timescale 1ns / 1ps
`default_nettype none

module btr_alu (
    input  btr_pkg::t_alu_req i_req,
    output logic [17:0]       o_result
);
    import btr_pkg::*;

    logic [15:0] prod;

    assign prod = i_req.a[7:0] * i_req.b[7:0];

    always_comb begin
        case (i_req.op)
            ALU_ADD: begin
                o_result = {{2{i_req.a[15]}}, i_req.a} + {{2{i_req.b[15]}}, i_req.b};
            end
            ALU_MUL: begin
                o_result = {2'b00, prod};
            end
            ALU_CSUB: begin
                // Subtract only when it does not go below zero.
                if (i_req.a >= i_req.b) begin
                    o_result = {2'b00, i_req.a - i_req.b};
                end else begin
                    o_result = {2'b00, i_req.a};
                end
            end
            ALU_SLT: begin
                o_result = {17'd0, $signed(i_req.a) < $signed(i_req.b)};
            end
            default: begin
                o_result = 18'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/btr_glyph_ram.sv
// Glyph store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module btr_glyph_ram #(
    parameter int ADDR_W = 11,
    parameter int DEPTH  = 2048
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_text_rasterizer.sv
// Top level of the bitmap text rasterizer: sequencer, cursor state and output register.
`timescale 1ns / 1ps
`default_nettype none

// Character generator for an LED panel. Font bytes are written into a glyph store, a begin
// item sets the text origin, and each character item moves the cursor and, for printable
// codes, produces font_height+2 result items, one per display row from the row above the
// glyph cell to the row below it. Each result carries a mask-clear span and the glyph's ink
// bits, leftmost pixel in bit 0; rows off the panel are still produced and the consumer
// clips them. The block handles one item at a time and stalls its input until that item
// is finished. A begin item only sets the cursor, a font byte write runs the address
// reduction steps and then writes the store, and a newline moves the cursor to a new line.
// A character runs through one shared arithmetic unit: for a glyph, the multiply steps
// S_MUL1 and S_MUL2 and the reduction steps locate it, a variable-width glyph cell then
// scans all width*height pixels at one pixel per cycle, S_CHK_L and S_CHK_R check the line
// wrap, and each inked row gathers width pixels at one per cycle before its result is
// offered until it is taken; both pixel rates hold only while read data is ready, and the
// stream waits whenever the pointer moves to a new glyph byte on the registered store port.
module bitmap_text_rasterizer #(
    parameter int DISPLAY_WIDTH = 128,
    parameter int MAX_GLYPH_W   = 8,
    parameter int MAX_GLYPH_H   = 16,
    parameter int FONT_BYTES    = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  btr_pkg::t_in_item       i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output btr_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import btr_pkg::*;

    localparam int ADDR_W    = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
    localparam int RED_Q     = FONT_ADDR_MAX / FONT_BYTES;
    localparam int RED_STEPS = (RED_Q > 0) ? $clog2(RED_Q + 1) : 1;
    localparam int RED_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL1  = 13'b0000000000010,
        S_MUL2  = 13'b0000000000100,
        S_RED   = 13'b0000000001000,
        S_SCAN  = 13'b0000000010000,
        S_NL    = 13'b0000000100000,
        S_CHK_L = 13'b0000001000000,
        S_CHK_R = 13'b0000010000000,
        S_BRK   = 13'b0000100000000,
        S_RINIT = 13'b0001000000000,
        S_ROW   = 13'b0010000000000,
        S_EMIT  = 13'b0100000000000,
        S_ADV   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [3:0] r_font_w;
    logic [4:0] r_font_h;
    logic [1:0] r_spacing;

    // Cursor state.
    logic [15:0] r_cx, n_cx;
    logic [15:0] r_cy, n_cy;
    logic [15:0] r_lx, n_lx;

    // Item being worked on.
    logic [1:0]  r_req, n_req;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_c, n_c;
    logic        r_var, n_var;
    logic        r_glyph, n_glyph;
    logic        r_draw, n_draw;
    logic        r_brk, n_brk;
    logic [3:0]  r_cw, n_cw;

    // Working value for the multiply and reduction steps.
    logic [15:0]      r_acc, n_acc;
    logic [RED_W-1:0] r_k, n_k;

    // Glyph bit stream: start of the glyph and the read pointer.
    logic [ADDR_W-1:0] r_sbyte, n_sbyte;
    logic [2:0]        r_sbit, n_sbit;
    logic [ADDR_W-1:0] r_pbyte, n_pbyte;
    logic [2:0]        r_pbit, n_pbit;
    logic              r_rd_ok, n_rd_ok;

    // Pixel scan and row counters.
    logic [2:0]  r_x, n_x;
    logic [3:0]  r_y, n_y;
    logic [2:0]  r_w, n_w;
    logic [4:0]  r_i, n_i;
    logic [7:0]  r_ink, n_ink;
    logic [15:0] r_row_y, n_row_y;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Shared unit and glyph store.
    t_alu_req          alu_req;
    logic [17:0]       alu_res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        rd_data;

    // Effective cell size and small helpers.
    logic [3:0]        fw;
    logic [4:0]        fh;
    logic              in_accept;
    logic              out_take;
    logic              pix;
    logic              lit_right;
    logic              inked_row;
    logic [ADDR_W-1:0] adv_byte;
    logic [2:0]        adv_bit;
    logic              c_var;
    logic              c_glyph;
    logic              c_draw;

    btr_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_res)
    );

    btr_glyph_ram #(
        .ADDR_W (ADDR_W),
        .DEPTH  (FONT_BYTES)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_byte),
        .i_raddr (r_pbyte),
        .o_rdata (rd_data)
    );

    // A width or height of zero acts as one, and one beyond the largest glyph is clamped.
    always_comb begin
        if (r_font_w == 4'd0) begin
            fw = 4'd1;
        end else if (r_font_w > 4'(MAX_GLYPH_W)) begin
            fw = 4'(MAX_GLYPH_W);
        end else begin
            fw = r_font_w;
        end
        if (r_font_h == 5'd0) begin
            fh = 5'd1;
        end else if (r_font_h > 5'(MAX_GLYPH_H)) begin
            fh = 5'(MAX_GLYPH_H);
        end else begin
            fh = r_font_h;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;

    // The pointer walks the packed bitstream, wrapping at the end of the store.
    assign pix      = rd_data[r_pbit];
    assign adv_bit  = r_pbit + 3'd1;
    assign adv_byte = (r_pbit != 3'd7) ? r_pbyte :
                      (r_pbyte == ADDR_W'(FONT_BYTES - 1)) ? '0 : r_pbyte + 1'b1;

    assign lit_right = pix && (r_x > r_w);
    assign inked_row = r_glyph && (r_i != 5'd0) && (r_i <= fh);

    assign c_glyph = i_in_item.char_code inside {[CH_BANG:CH_TILDE]};
    assign c_draw  = i_in_item.char_code inside {[CH_SPACE:CH_TILDE]};
    assign c_var   = (r_spacing == SP_VAR) ||
                     ((r_spacing == SP_TAB) && !(i_in_item.char_code inside {[CH_ZERO:CH_NINE]}));

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_lx        = r_lx;
        n_req       = r_req;
        n_byte      = r_byte;
        n_c         = r_c;
        n_var       = r_var;
        n_glyph     = r_glyph;
        n_draw      = r_draw;
        n_brk       = r_brk;
        n_cw        = r_cw;
        n_acc       = r_acc;
        n_k         = r_k;
        n_sbyte     = r_sbyte;
        n_sbit      = r_sbit;
        n_pbyte     = r_pbyte;
        n_pbit      = r_pbit;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_i         = r_i;
        n_ink       = r_ink;
        n_row_y     = r_row_y;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        alu_req.op  = ALU_ADD;
        alu_req.a   = 16'd0;
        alu_req.b   = 16'd0;
        mem_we      = 1'b0;
        mem_waddr   = alu_res[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_req = i_in_item.req_type;
                    case (i_in_item.req_type)
                        REQ_FONT: begin
                            n_acc   = {5'd0, i_in_item.font_addr};
                            n_byte  = i_in_item.font_byte;
                            n_k     = RED_W'(RED_STEPS - 1);
                            n_state = S_RED;
                        end
                        REQ_BEGIN: begin
                            n_cx = i_in_item.start_x;
                            n_cy = i_in_item.start_y;
                            n_lx = i_in_item.start_x;
                        end
                        REQ_CHAR: begin
                            n_c     = i_in_item.char_code;
                            n_var   = c_var;
                            n_glyph = c_glyph;
                            n_draw  = c_draw;
                            if (i_in_item.char_code == CH_NL) begin
                                n_state = S_NL;
                            end else if (c_glyph) begin
                                n_state = S_MUL1;
                            end else begin
                                n_cw    = c_var ? (fw >> 1) + 4'd1 : fw;
                                n_state = S_CHK_L;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MUL1: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = {12'd0, fw};
                alu_req.b  = {11'd0, fh};
                n_acc      = alu_res[15:0];
                n_state    = S_MUL2;
            end

            S_MUL2: begin
                // Bit offset of the glyph: cell size times its place after '!'.
                alu_req.op = ALU_MUL;
                alu_req.a  = r_acc;
                alu_req.b  = {8'd0, r_c - CH_BANG};
                n_acc      = {3'd0, alu_res[15:3]};
                n_sbit     = alu_res[2:0];
                n_k        = RED_W'(RED_STEPS - 1);
                n_state    = S_RED;
            end

            S_RED: begin
                // Byte address modulo the store size, one shifted compare-subtract per step.
                alu_req.op = ALU_CSUB;
                alu_req.a  = r_acc;
                alu_req.b  = 16'(FONT_BYTES) << r_k;
                n_acc      = alu_res[15:0];
                if (r_k != '0) begin
                    n_k = r_k - 1'b1;
                end else if (r_req == REQ_FONT) begin
                    mem_we  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_sbyte = alu_res[ADDR_W-1:0];
                    n_pbyte = alu_res[ADDR_W-1:0];
                    n_pbit  = r_sbit;
                    n_x     = 3'd0;
                    n_y     = 4'd0;
                    n_w     = 3'd0;
                    if (r_var) begin
                        n_state = S_SCAN;
                    end else begin
                        n_cw    = fw;
                        n_state = S_CHK_L;
                    end
                end
            end

            S_SCAN: begin
                // Find the rightmost lit column over the whole cell.
                if (r_rd_ok) begin
                    n_pbit  = adv_bit;
                    n_pbyte = adv_byte;
                    if (lit_right) begin
                        n_w = r_x;
                    end
                    if ({1'b0, r_x} == fw - 4'd1) begin
                        n_x = 3'd0;
                        if ({1'b0, r_y} == fh - 5'd1) begin
                            n_cw    = {1'b0, lit_right ? r_x : r_w} + 4'd1;
                            n_state = S_CHK_L;
                        end else begin
                            n_y = r_y + 4'd1;
                        end
                    end else begin
                        n_x = r_x + 3'd1;
                    end
                end
            end

            S_NL: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_cy;
                alu_req.b  = {11'd0, fh - 5'd1};
                n_cy       = alu_res[15:0];
                n_cx       = r_lx;
                n_state    = S_IDLE;
            end

            S_CHK_L: begin
                alu_req.op = ALU_SLT;
                alu_req.a  = r_lx;
                alu_req.b  = r_cx;
                n_brk      = alu_res[0];
                n_state    = S_CHK_R;
            end

            S_CHK_R: begin
                // The line breaks only when the cursor is right of the line start.
                alu_req.op = ALU_ADD;
                alu_req.a  = r_cx;
                alu_req.b  = {12'd0, r_cw};
                if (r_brk && ($signed(alu_res) > $signed(18'(DISPLAY_WIDTH)))) begin
                    n_cx    = r_lx;
                    n_state = S_BRK;
                end else if (r_draw) begin
                    n_state = S_RINIT;
                end else begin
                    n_state = S_ADV;
                end
            end

            S_BRK: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_cy;
                alu_req.b  = {11'd0, fh - 5'd1};
                n_cy       = alu_res[15:0];
                n_state    = r_draw ? S_RINIT : S_ADV;
            end

            S_RINIT: begin
                // The first row lies one above the cursor.
                alu_req.op = ALU_ADD;
                alu_req.a  = r_cy;
                alu_req.b  = 16'hFFFF;
                n_row_y    = alu_res[15:0];
                n_i        = 5'd0;
                n_x        = 3'd0;
                n_ink      = 8'd0;
                n_pbyte    = r_sbyte;
                n_pbit     = r_sbit;
                n_state    = S_ROW;
            end

            S_ROW: begin
                n_out.row_y       = r_row_y;
                n_out.region_x    = r_cx - 16'd1;
                n_out.clear_count = r_cw + 4'd2;
                n_out.last_row    = (r_i == fh + 5'd1);
                if (!inked_row) begin
                    n_out.ink_bits = 8'd0;
                    n_out_valid    = 1'b1;
                    n_state        = S_EMIT;
                end else if (r_rd_ok) begin
                    n_pbit  = adv_bit;
                    n_pbyte = adv_byte;
                    n_ink   = pix ? (r_ink | (8'd1 << r_x)) : r_ink;
                    if ({1'b0, r_x} == fw - 4'd1) begin
                        n_out.ink_bits = n_ink;
                        n_out_valid    = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        n_x = r_x + 3'd1;
                    end
                end
            end

            S_EMIT: begin
                if (out_take) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_row) begin
                        n_state = S_ADV;
                    end else begin
                        n_i     = r_i + 5'd1;
                        n_row_y = r_row_y + 16'd1;
                        n_x     = 3'd0;
                        n_ink   = 8'd0;
                        n_state = S_ROW;
                    end
                end
            end

            S_ADV: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_cx;
                alu_req.b  = {12'd0, r_cw + 4'd1};
                n_cx       = alu_res[15:0];
                n_state    = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read data is good when the pointer stayed on its byte and no font byte was written.
    assign n_rd_ok = (n_pbyte == r_pbyte) && !mem_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cx        <= 16'd0;
            r_cy        <= 16'd0;
            r_lx        <= 16'd0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_font_w    <= RST_FONT_W;
            r_font_h    <= RST_FONT_H;
            r_spacing   <= RST_SPACING;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_lx        <= n_lx;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= n_rd_ok;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FONT_W: begin
                        r_font_w <= i_cfg_data[3:0];
                    end
                    CFG_FONT_H: begin
                        r_font_h <= i_cfg_data[4:0];
                    end
                    CFG_SPACING: begin
                        r_spacing <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_byte  <= n_byte;
        r_c     <= n_c;
        r_var   <= n_var;
        r_glyph <= n_glyph;
        r_draw  <= n_draw;
        r_brk   <= n_brk;
        r_cw    <= n_cw;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_sbyte <= n_sbyte;
        r_sbit  <= n_sbit;
        r_pbyte <= n_pbyte;
        r_pbit  <= n_pbit;
        r_x     <= n_x;
        r_y     <= n_y;
        r_w     <= n_w;
        r_i     <= n_i;
        r_ink   <= n_ink;
        r_row_y <= n_row_y;
        r_out   <= n_out;
    end

    // A result is offered exactly while the sequencer waits for it to be taken.
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid == (r_state == S_EMIT))
        else $error("output valid out of step with the sequencer");

    // Taking the final row of a character leads straight to the cursor advance.
    a_last_to_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_out_item.last_row) |=> (r_state == S_ADV))
        else $error("final row not followed by cursor advance");

    // The row counter never passes the row below the glyph cell.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> ({1'b0, r_i} <= {1'b0, fh} + 6'd1))
        else $error("row index beyond the cell");

    // Every clear span, the cell plus one pixel on each side, stays between 3 and 10 pixels.
    a_clear_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.clear_count >= 4'd3) && (o_out_item.clear_count <= 4'd10)))
        else $error("clear span out of range");

endmodule

`default_nettype wire

>>> verif/tb_bitmap_text_rasterizer.sv
// Self-checking testbench of the bitmap text rasterizer: directed table, random text, row checks.
`timescale 1ns / 1ps

module tb_bitmap_text_rasterizer;
    import btr_pkg::*;

    localparam int DISPLAY_WIDTH = 128;
    localparam int MAX_GLYPH_W   = 8;
    localparam int MAX_GLYPH_H   = 16;
    localparam int FONT_BYTES    = 2048;

    // Codes that the package does not name.
    localparam logic [1:0] REQ_NONE    = 2'd3;
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam logic [1:0] SP_MONO_ALT = 2'd3;

    localparam int PREDICT      = -1;   // row count that means "ask the raster model"
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SEG_ITEMS    = 14;
    localparam int N_SETTINGS   = 8;
    localparam int REPORT_MAX   = 10;

    // Font geometry and spacing per test segment: reset values, the largest cell, the
    // smallest, out-of-range values on both sides, and a few ordinary ones.
    localparam logic [3:0] SET_FW [N_SETTINGS] = '{4'd5, 4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd6};
    localparam logic [4:0] SET_FH [N_SETTINGS] = '{5'd7, 5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd1,
                                                   5'd12};
    localparam logic [1:0] SET_SP [N_SETTINGS] = '{SP_MONO, SP_VAR, SP_TAB, SP_MONO_ALT, SP_VAR,
                                                   SP_TAB, SP_MONO, SP_TAB};

    // Idle and stall percentages of the four traffic phases, two segments each.
    localparam int IDLE_PCT  [4] = '{0, 77, 0, 38};
    localparam int STALL_PCT [4] = '{0, 0, 77, 38};

    typedef struct packed {
        logic [1:0] req;
        int         addr;
        int         data;
        int         sx;
        int         sy;
        int         ch;
        int         rows;   // PREDICT, or the number of blank rows typed in below
        int         y0;
        int         x0;
        int         cnt;
    } t_dir_row;

    typedef struct packed {
        t_in_item item;
        int       rows;
        int       y0;
        int       x0;
        int       cnt;
    } t_feed;

    // Directed part, run with the reset font of 5x7 monospace. Typed rows are blank rows
    // (space characters) whose first row, span and count are read off directly.
    localparam int DIR_N = 26;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{REQ_CHAR,  0,    0,     0,      0,      CH_SPACE, 9,       -1,    -1,    7},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_NL,    0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      255,      0,       0,     0,     0},
        '{REQ_FONT,  0,    'hFF,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  1,    'h00,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  2,    'hA5,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  3,    'h5A,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  4,    'h81,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_BANG,  PREDICT, 0,     0,     0},
        '{REQ_FONT,  2047, 'hFF,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  406,  'h3C,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  407,  'hFF,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  408,  'h00,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  409,  'h66,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  410,  'hFF,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_FONT,  411,  'h7E,  0,      0,      0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_TILDE, PREDICT, 0,     0,     0},
        '{REQ_NONE,  2047, 'hFF,  -1,     -1,     255,      0,       0,     0,     0},
        '{REQ_BEGIN, 0,    0,     32767,  32767,  0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_SPACE, 9,       32766, 32766, 7},
        '{REQ_BEGIN, 0,    0,     -32768, -32768, 0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_SPACE, 9,       32767, 32767, 7},
        '{REQ_BEGIN, 0,    0,     120,    0,      0,        0,       0,     0,     0},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_SPACE, 9,       -1,    119,   7},
        '{REQ_CHAR,  0,    0,     0,      0,      CH_BANG,  PREDICT, 0,     0,     0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   in_item = '0;
    logic       o_out_valid;
    logic       out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] cfg_index = CFG_FONT_W;
    logic [7:0] cfg_data = '0;

    // Raster model state: glyph store, pen position and the font registers.
    bit   [7:0]  glyph_mem [FONT_BYTES];
    logic [3:0]  font_w_reg = RST_FONT_W;
    logic [4:0]  font_h_reg = RST_FONT_H;
    logic [1:0]  spacing_reg = RST_SPACING;
    logic [15:0] pen_x = '0;
    logic [15:0] pen_y = '0;
    logic [15:0] line_x = '0;

    // Generator side: which store bytes have a font write queued so far.
    bit          byte_loaded [FONT_BYTES];

    t_feed       item_feed [$];
    t_feed       cur_feed;
    bit          in_taken = 1'b0;
    t_out_item   fresh_rows [$];
    t_out_item   pending_rows [$];
    int          fed_items = 0;
    int          bad_rows = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    bitmap_text_rasterizer #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH),
        .MAX_GLYPH_W  (MAX_GLYPH_W),
        .MAX_GLYPH_H  (MAX_GLYPH_H),
        .FONT_BYTES   (FONT_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned eff_width();
        if (font_w_reg == 0) return 1;
        return (font_w_reg > MAX_GLYPH_W) ? MAX_GLYPH_W : font_w_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (font_h_reg == 0) return 1;
        return (font_h_reg > MAX_GLYPH_H) ? MAX_GLYPH_H : font_h_reg;
    endfunction

    function automatic bit glyph_px(input int unsigned pos);
        return glyph_mem[(pos >> 3) % FONT_BYTES][pos & 7];
    endfunction

    // Proportional cell: rightmost lit column of the glyph plus one, or half the width plus one without a glyph.
    function automatic int unsigned prop_width(input int unsigned code, input int unsigned fw,
                                               input int unsigned fh);
        int unsigned base;
        int unsigned w;
        if (code < CH_BANG || code > CH_TILDE) return fw / 2 + 1;
        base = fw * fh * (code - CH_BANG);
        w = 0;
        for (int unsigned y = 0; y < fh; y++)
            for (int unsigned x = 0; x < fw; x++)
                if (glyph_px(base + y * fw + x) && x > w) w = x;
        return w + 1;
    endfunction

    // Applies one accepted item to the model state and leaves its rows in fresh_rows.
    function automatic void raster_item(input t_in_item it);
        int unsigned fw;
        int unsigned fh;
        int unsigned cw;
        int unsigned code;
        int unsigned base;
        bit          prop_cell;
        logic [7:0]  ink;
        t_out_item   row;
        fw = eff_width();
        fh = eff_height();
        code = it.char_code;
        case (it.req_type)
            REQ_FONT: glyph_mem[it.font_addr] = it.font_byte;
            REQ_BEGIN: begin
                pen_x = it.start_x;
                pen_y = it.start_y;
                line_x = it.start_x;
            end
            REQ_CHAR: begin
                if (it.char_code == CH_NL) begin
                    pen_x = line_x;
                    pen_y = pen_y + 16'(fh - 1);
                end else begin
                    prop_cell = (spacing_reg == SP_VAR) ||
                                (spacing_reg == SP_TAB && (code < CH_ZERO || code > CH_NINE));
                    cw = prop_cell ? prop_width(code, fw, fh) : fw;
                    // Break the line first when the cell would run off the right edge.
                    if ($signed(pen_x) > $signed(line_x) &&
                        int'($signed(pen_x)) + int'(cw) > DISPLAY_WIDTH) begin
                        pen_x = line_x;
                        pen_y = pen_y + 16'(fh - 1);
                    end
                    if (code >= CH_SPACE && code <= CH_TILDE) begin
                        for (int i = 0; i < int'(fh) + 2; i++) begin
                            ink = '0;
                            if (code != CH_SPACE && i >= 1 && i <= int'(fh)) begin
                                base = fw * fh * (code - CH_BANG) + (i - 1) * fw;
                                for (int x = 0; x < int'(fw); x++) ink[x] = glyph_px(base + x);
                            end
                            row.row_y       = pen_y + 16'(i) - 16'd1;
                            row.region_x    = pen_x - 16'd1;
                            row.clear_count = 4'(cw + 2);
                            row.ink_bits    = ink;
                            row.last_row    = (i == int'(fh) + 1);
                            fresh_rows.push_back(row);
                        end
                    end
                    pen_x = pen_x + 16'(cw + 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        bad_rows++;
        if (bad_rows <= REPORT_MAX) $display("%s", msg);
    endfunction

    // Input side: a new item is offered only once the previous one has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (item_feed.size() != 0 &&
                !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
                cur_feed = item_feed.pop_front();
                in_item  <= cur_feed.item;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Accepted items feed the raster model; typed rows replace its rows in the directed part.
    always @(posedge i_clk) begin
        t_out_item row;
        if (i_rst_n && in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            fresh_rows.delete();
            raster_item(cur_feed.item);
            if (cur_feed.rows == PREDICT) begin
                foreach (fresh_rows[k]) pending_rows.push_back(fresh_rows[k]);
            end else begin
                for (int k = 0; k < cur_feed.rows; k++) begin
                    row.row_y       = 16'(cur_feed.y0 + k);
                    row.region_x    = 16'(cur_feed.x0);
                    row.clear_count = 4'(cur_feed.cnt);
                    row.ink_bits    = '0;
                    row.last_row    = (k == cur_feed.rows - 1);
                    pending_rows.push_back(row);
                end
            end
        end
    end

    // Output side: every accepted row is checked against the oldest expected row.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_rows.size() == 0) begin
                flag_error($sformatf("unexpected row: y=%0d x=%0d clr=%0d ink=%02h last=%0b",
                                     o_out_item.row_y, o_out_item.region_x,
                                     o_out_item.clear_count, o_out_item.ink_bits,
                                     o_out_item.last_row));
            end else begin
                want = pending_rows.pop_front();
                if (o_out_item.row_y !== want.row_y || o_out_item.region_x !== want.region_x ||
                    o_out_item.clear_count !== want.clear_count ||
                    o_out_item.ink_bits !== want.ink_bits ||
                    o_out_item.last_row !== want.last_row) begin
                    flag_error($sformatf({"row mismatch: want y=%0d x=%0d clr=%0d ink=%02h ",
                                          "last=%0b, got y=%0d x=%0d clr=%0d ink=%02h last=%0b"},
                                         want.row_y, want.region_x, want.clear_count,
                                         want.ink_bits, want.last_row, o_out_item.row_y,
                                         o_out_item.region_x, o_out_item.clear_count,
                                         o_out_item.ink_bits, o_out_item.last_row));
                end
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_req(input t_in_item it, input int rows, input int y0, input int x0,
                             input int cnt);
        t_feed f;
        f.item = it;
        f.rows = rows;
        f.y0   = y0;
        f.x0   = x0;
        f.cnt  = cnt;
        item_feed.push_back(f);
        if (it.req_type != REQ_NONE) fed_items++;
    endtask

    // Waits until every item is taken and every row has come, then lets the block settle.
    task automatic wait_quiet();
        do @(posedge i_clk); while (item_feed.size() != 0 || in_valid || pending_rows.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FONT_W:  font_w_reg  = data[3:0];
            CFG_FONT_H:  font_h_reg  = data[4:0];
            CFG_SPACING: spacing_reg = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item rand_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[60:0];
    endfunction

    // A glyph may be drawn only once every store byte it covers at this size is written.
    function automatic bit glyph_ready(input logic [7:0] code);
        int unsigned bits;
        int unsigned base;
        if (code < CH_BANG || code > CH_TILDE) return 1'b1;
        bits = eff_width() * eff_height();
        base = bits * (code - CH_BANG);
        for (int unsigned b = base >> 3; b <= (base + bits - 1) >> 3; b++)
            if (!byte_loaded[b % FONT_BYTES]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic load_glyph(input logic [7:0] code);
        t_in_item    it;
        int unsigned bits;
        int unsigned base;
        int          r;
        bits = eff_width() * eff_height();
        base = bits * (code - CH_BANG);
        for (int unsigned b = base >> 3; b <= (base + bits - 1) >> 3; b++) begin
            it = rand_item();
            it.req_type  = REQ_FONT;
            it.font_addr = 11'(b);
            r = $urandom_range(99);
            if (r < 10) it.font_byte = 8'h00;
            else if (r < 20) it.font_byte = 8'hFF;
            byte_loaded[b % FONT_BYTES] = 1'b1;
            queue_req(it, PREDICT, 0, 0, 0);
        end
    endtask

    function automatic logic [7:0] pick_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 8) return CH_NL;
        if (r < 18) begin
            if ($urandom_range(1) == 0) begin
                do c = 8'($urandom_range(31)); while (c == CH_NL);
            end else begin
                c = 8'($urandom_range(255, CH_TILDE + 1));
            end
            return c;
        end
        if (r < 28) return CH_SPACE;
        repeat (10) begin
            if ($urandom_range(99) < 35) c = 8'($urandom_range(CH_NINE, CH_ZERO));
            else c = 8'($urandom_range(CH_TILDE, CH_BANG));
            if (glyph_ready(c)) return c;
        end
        return CH_SPACE;
    endfunction

    // One line of text: maybe a glyph load, maybe noise, usually a new origin, then characters.
    task automatic gen_sequence();
        t_in_item   it;
        logic [7:0] code;
        int         r;
        if ($urandom_range(99) < 40) begin
            if ($urandom_range(99) < 40) code = 8'($urandom_range(CH_NINE, CH_ZERO));
            else code = 8'($urandom_range(CH_TILDE, CH_BANG));
            if (!glyph_ready(code) || $urandom_range(99) < 25) load_glyph(code);
        end
        if ($urandom_range(99) < 8) begin
            it = rand_item();
            it.req_type = REQ_FONT;
            byte_loaded[it.font_addr] = 1'b1;
            queue_req(it, PREDICT, 0, 0, 0);
        end
        if ($urandom_range(99) < 5) begin
            it = rand_item();
            it.req_type = REQ_NONE;
            queue_req(it, PREDICT, 0, 0, 0);
        end
        if ($urandom_range(99) < 85) begin
            it = rand_item();
            it.req_type = REQ_BEGIN;
            r = $urandom_range(99);
            // Origins near the right edge make the wrap happen; a few are anywhere at all.
            if (r < 25) begin
                it.start_x = 16'($urandom_range(DISPLAY_WIDTH - 1, DISPLAY_WIDTH - 32));
                it.start_y = 16'($urandom_range(90) - 20);
            end else if (r < 85) begin
                it.start_x = 16'($urandom_range(140) - 10);
                it.start_y = 16'($urandom_range(90) - 20);
            end
            queue_req(it, PREDICT, 0, 0, 0);
        end
        repeat ($urandom_range(5, 1)) begin
            it = rand_item();
            it.req_type  = REQ_CHAR;
            it.char_code = pick_char();
            queue_req(it, PREDICT, 0, 0, 0);
        end
    endtask

    initial begin
        t_in_item it;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            it = '0;
            it.req_type  = DIR_TAB[k].req;
            it.font_addr = 11'(DIR_TAB[k].addr);
            it.font_byte = 8'(DIR_TAB[k].data);
            it.start_x   = 16'(DIR_TAB[k].sx);
            it.start_y   = 16'(DIR_TAB[k].sy);
            it.char_code = 8'(DIR_TAB[k].ch);
            if (it.req_type == REQ_FONT) byte_loaded[it.font_addr] = 1'b1;
            queue_req(it, DIR_TAB[k].rows, DIR_TAB[k].y0, DIR_TAB[k].x0, DIR_TAB[k].cnt);
        end

        for (int s = 0; s < N_SETTINGS; s++) begin
            // The first segment keeps the reset font; later ones reprogram it while idle.
            if (s != 0) begin
                wait_quiet();
                write_reg(CFG_FONT_W, {4'($urandom), SET_FW[s]});
                write_reg(CFG_FONT_H, {3'($urandom), SET_FH[s]});
                write_reg(CFG_SPACING, {6'($urandom), SET_SP[s]});
                if (s == 3) write_reg(CFG_UNUSED, 8'($urandom));
                @(posedge i_clk);
            end
            send_idle_pct  = IDLE_PCT[s / 2];
            recv_stall_pct = STALL_PCT[s / 2];
            fed_items = 0;
            while (fed_items < SEG_ITEMS) gen_sequence();
        end

        wait_quiet();
        if (pending_rows.size() != 0)
            flag_error($sformatf("%0d expected rows never came", pending_rows.size()));
        if (bad_rows == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
